### rtl/tcce_pkg.sv
// Shared types, constants and codes for the text console character engine.
// No dependencies; the other files refer to this package by scoped name or import it.
`timescale 1ns / 1ps

package tcce_pkg;

  // Default store geometry
  localparam int MAX_ROWS_DEF = 32;
  localparam int MAX_COLS_DEF = 128;

  // Fixed field widths
  localparam int CH_W       = 8;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int ROWS_CFG_W = 6;
  localparam int COLS_CFG_W = 8;
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COLS = 1'd1;

  localparam logic [ROWS_CFG_W-1:0] ROWS_RST = 6'd25;
  localparam logic [COLS_CFG_W-1:0] COLS_RST = 8'd80;

  // Request function codes
  localparam logic FUNC_PUT  = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // Character codes
  localparam logic [CH_W-1:0] CH_BS = 8'h08;
  localparam logic [CH_W-1:0] CH_LF = 8'h0A;
  localparam logic [CH_W-1:0] CH_FF = 8'h0C;
  localparam logic [CH_W-1:0] CH_CR = 8'h0D;
  localparam logic [CH_W-1:0] CH_SP = 8'h20;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_FF,
    S_CPRD,
    S_CPWR,
    S_BLANK
  } state_t;

  // Actions the cursor unit asks of the sequencer
  typedef struct packed {
    logic wr;
    logic clr;
    logic scr;
  } cur_ctl_t;

endpackage

### rtl/tcce_store.sv
// Character store: one write port, one read port with registered read data.
// Depends on tcce_pkg for the character width.
`timescale 1ns / 1ps

module tcce_store #(
  parameter int AW = 12
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [tcce_pkg::CH_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [tcce_pkg::CH_W-1:0] rd_data
);

  logic [tcce_pkg::CH_W-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

### rtl/tcce_cursor.sv
// Cursor unit: saturates the cursor into the active area and works out the
// cursor move and store action for one put byte. Depends on tcce_pkg.
`timescale 1ns / 1ps

module tcce_cursor #(
  parameter int MAX_ROWS = tcce_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = tcce_pkg::MAX_COLS_DEF
) (
  input  logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] cur_x,
  input  logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] cur_y,
  input  logic [$clog2(MAX_ROWS + 1)-1:0]                    rows,
  input  logic [$clog2(MAX_COLS + 1)-1:0]                    cols,
  input  logic [tcce_pkg::CH_W-1:0]                          ch,
  output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] x0,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] y0,
  output logic [((MAX_COLS > 1) ? $clog2(MAX_COLS) : 1)-1:0] nx,
  output logic [((MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1)-1:0] ny,
  output tcce_pkg::cur_ctl_t                                 ctl
);

  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ECW = $clog2(MAX_COLS + 1);
  localparam int ERW = $clog2(MAX_ROWS + 1);

  logic [CW-1:0]  xl;
  logic [RW-1:0]  yl;
  logic [ECW-1:0] x1;
  logic [ERW-1:0] y1;
  logic           wrap;
  logic [RW-1:0]  ydn;

  assign xl   = CW'(cols - ECW'(1));
  assign yl   = RW'(rows - ERW'(1));
  assign x0   = (ECW'(cur_x) >= cols) ? xl : cur_x;
  assign y0   = (ERW'(cur_y) >= rows) ? yl : cur_y;
  assign x1   = ECW'(x0) + ECW'(1);
  assign y1   = ERW'(y0) + ERW'(1);
  // stepping off the last row pins the cursor there and asks for a scroll
  assign wrap = (y1 >= rows);
  assign ydn  = wrap ? yl : RW'(y1);

  always_comb begin
    nx  = x0;
    ny  = y0;
    ctl = '0;
    case (ch)
      tcce_pkg::CH_BS: begin
        if (x0 != '0) begin
          nx = x0 - CW'(1);
        end else if (y0 != '0) begin
          nx = xl;
          ny = y0 - RW'(1);
        end
      end
      tcce_pkg::CH_CR: begin
        nx = '0;
      end
      tcce_pkg::CH_LF: begin
        nx      = '0;
        ny      = ydn;
        ctl.scr = wrap;
      end
      tcce_pkg::CH_FF: begin
        nx      = '0;
        ny      = '0;
        ctl.clr = 1'b1;
      end
      default: begin
        ctl.wr = 1'b1;
        if (x1 >= cols) begin
          nx      = '0;
          ny      = ydn;
          ctl.scr = wrap;
        end else begin
          nx = CW'(x1);
        end
      end
    endcase
  end

endmodule

### rtl/text_console_char_engine.sv
// A read, an ordinary byte, BS, CR and LF without scroll pass through the execute state,
//   which registers their result; the next request is taken only once back in idle.
// A scroll adds a full-width copy of rows-1 rows (a read, then a write per cell) and a blank
//   fill of the last active row: one store access per cycle via the single store port pair.
// Form feed adds a blank sweep over all MAX_ROWS*MAX_COLS cells (4096 at the defaults).
// Reset: a clearing pass over all MAX_ROWS*MAX_COLS cells runs first, with in_stall high.
`timescale 1ns / 1ps

module text_console_char_engine #(
  parameter int MAX_ROWS = tcce_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS = tcce_pkg::MAX_COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_func,
  input  logic [tcce_pkg::CH_W-1:0]       in_ch,
  input  logic [tcce_pkg::ROW_W-1:0]      in_read_row,
  input  logic [tcce_pkg::COL_W-1:0]      in_read_col,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tcce_pkg::CH_W-1:0]       out_read_char,
  output logic [tcce_pkg::COL_W-1:0]      out_cursor_col,
  output logic [tcce_pkg::ROW_W-1:0]      out_cursor_row,
  output logic                            out_scrolled,
  // configuration
  input  logic                            cfg_we,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int CW   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ECW  = $clog2(MAX_COLS + 1);
  localparam int ERW  = $clog2(MAX_ROWS + 1);
  localparam int AW   = RW + CW;
  localparam int COLW = tcce_pkg::COL_W;
  localparam int ROWW = tcce_pkg::ROW_W;

  tcce_pkg::state_t state_r, state_nxt;

  // configuration registers
  logic [tcce_pkg::ROWS_CFG_W-1:0] rows_cfg_r;
  logic [tcce_pkg::COLS_CFG_W-1:0] cols_cfg_r;
  logic [ERW-1:0]                  rows_eff;
  logic [ECW-1:0]                  cols_eff;
  logic [RW-1:0]                   ylast;

  // cursor
  logic [CW-1:0] cur_x_r;
  logic [RW-1:0] cur_y_r;
  logic [CW-1:0] cur_x0, cur_nx;
  logic [RW-1:0] cur_y0, cur_ny;
  tcce_pkg::cur_ctl_t cur_ctl;

  // held request
  logic                       req_func_r;
  logic [tcce_pkg::CH_W-1:0]  req_ch_r;
  logic [tcce_pkg::ROW_W-1:0] req_row_r;
  logic [tcce_pkg::COL_W-1:0] req_col_r;

  // sweep counters for clear, copy and blank fill
  logic [RW-1:0] sr_r, sr_nxt;
  logic [CW-1:0] sc_r, sc_nxt;
  logic [RW-1:0] src_row;
  logic          sc_last;
  logic          row_done;
  logic          step;
  logic          sweep_done;

  // store ports
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [tcce_pkg::CH_W-1:0] mem_wdata;
  logic [AW-1:0]             mem_raddr;
  logic [tcce_pkg::CH_W-1:0] mem_rdata;

  // result
  logic                      out_valid_r, out_valid_nxt;
  logic [tcce_pkg::CH_W-1:0] out_char_r;
  logic                      scr_r;
  logic                      finish;
  logic                      in_acc;
  logic                      is_put;
  logic                      rd_in_area;

  // ---------------------------------------------------------------------------
  // Effective geometry: zero acts as one, anything above the store size is
  // clipped to it.
  // ---------------------------------------------------------------------------
  always_comb begin
    if (rows_cfg_r == '0) begin
      rows_eff = ERW'(1);
    end else if (32'(rows_cfg_r) > MAX_ROWS) begin
      rows_eff = ERW'(MAX_ROWS);
    end else begin
      rows_eff = ERW'(rows_cfg_r);
    end
    if (cols_cfg_r == '0) begin
      cols_eff = ECW'(1);
    end else if (32'(cols_cfg_r) > MAX_COLS) begin
      cols_eff = ECW'(MAX_COLS);
    end else begin
      cols_eff = ECW'(cols_cfg_r);
    end
  end

  assign ylast = RW'(rows_eff - ERW'(1));

  tcce_cursor #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_cursor (
    .cur_x (cur_x_r),
    .cur_y (cur_y_r),
    .rows  (rows_eff),
    .cols  (cols_eff),
    .ch    (req_ch_r),
    .x0    (cur_x0),
    .y0    (cur_y0),
    .nx    (cur_nx),
    .ny    (cur_ny),
    .ctl   (cur_ctl)
  );

  tcce_store #(
    .AW (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // ---------------------------------------------------------------------------
  // Handshake. Take a request only in idle and only when the result slot is
  // free or being emptied at this edge.
  // ---------------------------------------------------------------------------
  assign in_stall = (state_r != tcce_pkg::S_IDLE) || (out_valid_r && out_stall);
  assign in_acc   = in_valid && !in_stall;
  assign is_put   = (req_func_r == tcce_pkg::FUNC_PUT);

  assign rd_in_area = (32'(req_row_r) < 32'(rows_eff)) && (32'(req_col_r) < 32'(cols_eff));

  // ---------------------------------------------------------------------------
  // Sweep walker: column runs across the full store width, then the row
  // advances. Each sweep state decides which row is its last.
  // ---------------------------------------------------------------------------
  assign src_row = sr_r + RW'(1);
  assign sc_last = (sc_r == CW'(MAX_COLS - 1));
  assign step    = (state_r == tcce_pkg::S_INIT) || (state_r == tcce_pkg::S_FF) ||
                   (state_r == tcce_pkg::S_CPWR) || (state_r == tcce_pkg::S_BLANK);

  always_comb begin
    case (state_r)
      tcce_pkg::S_INIT,
      tcce_pkg::S_FF:    row_done = (sr_r == RW'(MAX_ROWS - 1));
      tcce_pkg::S_CPWR:  row_done = (src_row == ylast);
      tcce_pkg::S_BLANK: row_done = 1'b1;
      default:           row_done = 1'b0;
    endcase
  end

  assign sweep_done = step && sc_last && row_done;

  always_comb begin
    sr_nxt = sr_r;
    sc_nxt = sc_r;
    if (step) begin
      if (sc_last) begin
        sc_nxt = '0;
        sr_nxt = row_done ? '0 : src_row;
      end else begin
        sc_nxt = sc_r + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcce_pkg::S_INIT: begin
        if (sweep_done) state_nxt = tcce_pkg::S_IDLE;
      end
      tcce_pkg::S_IDLE: begin
        if (in_acc) state_nxt = tcce_pkg::S_EXEC;
      end
      tcce_pkg::S_EXEC: begin
        if (is_put && cur_ctl.clr) begin
          state_nxt = tcce_pkg::S_FF;
        end else if (is_put && cur_ctl.scr) begin
          // a single active row has nothing to move: go straight to the blank fill
          state_nxt = (ylast == '0) ? tcce_pkg::S_BLANK : tcce_pkg::S_CPRD;
        end else begin
          state_nxt = tcce_pkg::S_IDLE;
        end
      end
      tcce_pkg::S_FF: begin
        if (sweep_done) state_nxt = tcce_pkg::S_IDLE;
      end
      tcce_pkg::S_CPRD: begin
        state_nxt = tcce_pkg::S_CPWR;
      end
      tcce_pkg::S_CPWR: begin
        state_nxt = sweep_done ? tcce_pkg::S_BLANK : tcce_pkg::S_CPRD;
      end
      tcce_pkg::S_BLANK: begin
        if (sweep_done) state_nxt = tcce_pkg::S_IDLE;
      end
      default: begin
        state_nxt = tcce_pkg::S_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: store accesses and completion
  // ---------------------------------------------------------------------------
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {sr_r, sc_r};
    mem_wdata = tcce_pkg::CH_SP;
    // in idle, look up the cell on the request lines so a read has its data next cycle
    mem_raddr = (state_r == tcce_pkg::S_IDLE) ?
                {RW'(in_read_row), CW'(in_read_col)} : {src_row, sc_r};
    finish    = 1'b0;
    case (state_r)
      tcce_pkg::S_INIT,
      tcce_pkg::S_FF: begin
        mem_we = 1'b1;
        finish = (state_r == tcce_pkg::S_FF) && sweep_done;
      end
      tcce_pkg::S_EXEC: begin
        mem_we    = is_put && cur_ctl.wr;
        mem_waddr = {cur_y0, cur_x0};
        mem_wdata = req_ch_r;
        finish    = !(is_put && (cur_ctl.clr || cur_ctl.scr));
      end
      tcce_pkg::S_CPWR: begin
        // move the cell fetched from the row below up one row
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      tcce_pkg::S_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = {ylast, sc_r};
        finish    = sweep_done;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (finish) out_valid_nxt = 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcce_pkg::S_INIT;
      rows_cfg_r  <= tcce_pkg::ROWS_RST;
      cols_cfg_r  <= tcce_pkg::COLS_RST;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      sr_r        <= '0;
      sc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sr_r        <= sr_nxt;
      sc_r        <= sc_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          tcce_pkg::REG_ACTIVE_ROWS: rows_cfg_r <= cfg_data[tcce_pkg::ROWS_CFG_W-1:0];
          tcce_pkg::REG_ACTIVE_COLS: cols_cfg_r <= cfg_data[tcce_pkg::COLS_CFG_W-1:0];
          default: ;
        endcase
      end
      // commit the final cursor straight away; scroll and clear only touch the store
      if (state_r == tcce_pkg::S_EXEC && is_put) begin
        cur_x_r <= cur_nx;
        cur_y_r <= cur_ny;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Payload registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_func_r <= in_func;
      req_ch_r   <= in_ch;
      req_row_r  <= in_read_row;
      req_col_r  <= in_read_col;
    end
    if (state_r == tcce_pkg::S_EXEC) begin
      out_char_r <= (!is_put && rd_in_area) ? mem_rdata : tcce_pkg::CH_SP;
      scr_r      <= is_put && cur_ctl.scr;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_char  = out_char_r;
  assign out_cursor_col = COLW'(cur_x_r);
  assign out_cursor_row = ROWW'(cur_y_r);
  assign out_scrolled   = scr_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_acc_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == tcce_pkg::S_EXEC))
    else $error("accepted request did not enter execution");

  a_cursor_in_area: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcce_pkg::S_EXEC && is_put) |=>
      ((32'(cur_x_r) < 32'(cols_eff)) && (32'(cur_y_r) < 32'(rows_eff))))
    else $error("cursor left the active area after a put");

  a_scroll_last_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && scr_r) |-> (cur_y_r == ylast))
    else $error("scrolled result with cursor off the last row");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcce_pkg::S_IDLE) |-> !mem_we)
    else $error("store written while idle");

  a_sweep_from_home: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcce_pkg::S_IDLE) |-> (sr_r == '0 && sc_r == '0))
    else $error("sweep counters not parked at home in idle");

endmodule

### dv/tcce_console_checker.sv
`timescale 1ns / 1ps
// Response checker for the text console character engine: mirrors the cell store,
// the cursor and the geometry registers, predicts every response and compares it.
// Depends on tcce_pkg for widths, register indexes and character codes.

module tcce_console_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            in_func,
  input  logic [tcce_pkg::CH_W-1:0]       in_ch,
  input  logic [tcce_pkg::ROW_W-1:0]      in_read_row,
  input  logic [tcce_pkg::COL_W-1:0]      in_read_col,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [tcce_pkg::CH_W-1:0]       out_read_char,
  input  logic [tcce_pkg::COL_W-1:0]      out_cursor_col,
  input  logic [tcce_pkg::ROW_W-1:0]      out_cursor_row,
  input  logic                            out_scrolled,
  input  logic                            cfg_we,
  input  logic [tcce_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tcce_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              outstanding,
  output int                              scrolls_predicted
);
  import tcce_pkg::*;

  localparam int ROWS_MAX = MAX_ROWS_DEF;
  localparam int COLS_MAX = MAX_COLS_DEF;

  typedef struct packed {
    logic [CH_W-1:0]  read_char;
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic             scrolled;
  } console_resp_t;

  logic [CH_W-1:0]       cell_mem [ROWS_MAX*COLS_MAX];
  int unsigned           cur_x;
  int unsigned           cur_y;
  logic [ROWS_CFG_W-1:0] rows_reg;
  logic [COLS_CFG_W-1:0] cols_reg;
  console_resp_t         resp_q[$];
  int                    mismatches;
  int                    scroll_tally;

  function automatic void blank_screen();
    foreach (cell_mem[i]) cell_mem[i] = CH_SP;
  endfunction

  // Apply one request to the mirrored console and return the response it gives.
  function automatic console_resp_t console_apply(logic func, logic [CH_W-1:0] ch,
                                                  logic [ROW_W-1:0] rrow,
                                                  logic [COL_W-1:0] rcol);
    int unsigned   rows;
    int unsigned   cols;
    console_resp_t resp;
    rows = (rows_reg == 0) ? 1 : (rows_reg > ROWS_MAX) ? ROWS_MAX : rows_reg;
    cols = (cols_reg == 0) ? 1 : (cols_reg > COLS_MAX) ? COLS_MAX : cols_reg;
    resp.read_char = CH_SP;
    resp.scrolled  = 1'b0;
    if (func == FUNC_READ) begin
      if (rrow < rows && rcol < cols)
        resp.read_char = cell_mem[int'(rrow) * COLS_MAX + int'(rcol)];
    end else begin
      // pull a stale cursor back into a shrunken area first
      if (cur_x >= cols) cur_x = cols - 1;
      if (cur_y >= rows) cur_y = rows - 1;
      case (ch)
        CH_BS: begin
          if (cur_x > 0) begin
            cur_x--;
          end else if (cur_y > 0) begin
            cur_x = cols - 1;
            cur_y--;
          end
        end
        CH_CR: cur_x = 0;
        CH_LF: begin
          cur_x = 0;
          cur_y++;
        end
        CH_FF: begin
          blank_screen();
          cur_x = 0;
          cur_y = 0;
        end
        default: begin
          cell_mem[cur_y * COLS_MAX + cur_x] = ch;
          cur_x++;
          if (cur_x >= cols) begin
            cur_x = 0;
            cur_y++;
          end
        end
      endcase
      if (cur_y >= rows) begin
        // rows move up at full store width, bottom active row blanked
        for (int i = 0; i < (rows - 1) * COLS_MAX; i++) cell_mem[i] = cell_mem[i + COLS_MAX];
        for (int i = 0; i < COLS_MAX; i++) cell_mem[(rows - 1) * COLS_MAX + i] = CH_SP;
        cur_y = rows - 1;
        resp.scrolled = 1'b1;
      end
    end
    resp.cursor_col = cur_x[COL_W-1:0];
    resp.cursor_row = cur_y[ROW_W-1:0];
    return resp;
  endfunction

  function automatic int field_check(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin : watch_channels
    console_resp_t want;
    if (!rst_n) begin
      blank_screen();
      cur_x        = 0;
      cur_y        = 0;
      rows_reg     = ROWS_RST;
      cols_reg     = COLS_RST;
      mismatches   = 0;
      scroll_tally = 0;
      resp_q.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_ACTIVE_ROWS) rows_reg = cfg_data[ROWS_CFG_W-1:0];
        else if (cfg_index == REG_ACTIVE_COLS) cols_reg = cfg_data[COLS_CFG_W-1:0];
      end
      // push before pop: a response never belongs to a request taken at the same edge
      if (in_valid && !in_stall) begin
        want = console_apply(in_func, in_ch, in_read_row, in_read_col);
        if (want.scrolled) scroll_tally++;
        resp_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (resp_q.size() == 0) begin
          $display("%0t: response with none pending, expected nothing got char %0d col %0d row %0d",
                   $time, out_read_char, out_cursor_col, out_cursor_row);
          mismatches++;
        end else begin
          want = resp_q.pop_front();
          mismatches += field_check("read_char", want.read_char, out_read_char);
          mismatches += field_check("cursor_col", want.cursor_col, out_cursor_col);
          mismatches += field_check("cursor_row", want.cursor_row, out_cursor_row);
          mismatches += field_check("scrolled", want.scrolled, out_scrolled);
        end
      end
    end
    fail_count        <= mismatches;
    outstanding       <= resp_q.size();
    scrolls_predicted <= scroll_tally;
  end

  final begin
    if (resp_q.size() != 0)
      $display("%0t: %0d responses still expected, got none", $time, resp_q.size());
  end

endmodule

### dv/tb_text_console_char_engine.sv
`timescale 1ns / 1ps
// Top of the text console character engine testbench: makes requests and settings,
// drives both handshakes and gives the verdict. Depends on tcce_pkg, the engine
// and tcce_console_checker.

module tb_text_console_char_engine;
  import tcce_pkg::*;

  // Slowest correct run: every request a full 32-row scroll plus stalls, for ~1.1k
  // requests, plus the clearing pass; taken three times over.
  localparam int CYCLE_LIMIT = 30_000_000;
  localparam int PHASES      = 8;

  logic                  clk;
  logic                  rst_n          = 1'b0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic                  in_func        = FUNC_PUT;
  logic [CH_W-1:0]       in_ch          = '0;
  logic [ROW_W-1:0]      in_read_row    = '0;
  logic [COL_W-1:0]      in_read_col    = '0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic [CH_W-1:0]       out_read_char;
  logic [COL_W-1:0]      out_cursor_col;
  logic [ROW_W-1:0]      out_cursor_row;
  logic                  out_scrolled;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index      = REG_ACTIVE_ROWS;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;

  int fail_count;
  int outstanding;
  int scrolls_predicted;
  int send_idle_pct  = 8;
  int recv_stall_pct = 81;
  int req_total      = 0;
  int cycles         = 0;

  // Geometry per phase: raw register writes, out-of-range values included
  // (the row write also carries junk above bit 5 in the first phase).
  logic [CFG_DATA_W-1:0] rows_tab  [PHASES] = '{8'hC4, 8'd1, 8'd0, 8'd63,
                                               8'd32, 8'd3, 8'd8, 8'd25};
  logic [CFG_DATA_W-1:0] cols_tab  [PHASES] = '{8'd6, 8'd1, 8'd0, 8'd1,
                                               8'd255, 8'd128, 8'd17, 8'd80};
  int                    items_tab [PHASES] = '{200, 100, 60, 60, 150, 150, 200, 180};

  text_console_char_engine dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_ch          (in_ch),
    .in_read_row    (in_read_row),
    .in_read_col    (in_read_col),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_char  (out_read_char),
    .out_cursor_col (out_cursor_col),
    .out_cursor_row (out_cursor_row),
    .out_scrolled   (out_scrolled),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  tcce_console_checker u_console_chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_ch             (in_ch),
    .in_read_row       (in_read_row),
    .in_read_col       (in_read_col),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_read_char     (out_read_char),
    .out_cursor_col    (out_cursor_col),
    .out_cursor_row    (out_cursor_row),
    .out_scrolled      (out_scrolled),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .fail_count        (fail_count),
    .outstanding       (outstanding),
    .scrolls_predicted (scrolls_predicted)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Receiver side: stall at random at the current rate, never during reset.
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Watchdog: end the run if it hangs anywhere.
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped after %0d cycles with %0d responses outstanding", cycles, outstanding);
    $display("text_console_char_engine: mismatch");
    $finish;
  end

  // Offer one request and hold it until the engine takes it. Valid stays high
  // into the next request unless an idle gap is drawn.
  task automatic send_request(input logic func, input logic [CH_W-1:0] ch,
                              input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_valid    <= 1'b1;
    in_func     <= func;
    in_ch       <= ch;
    in_read_row <= row;
    in_read_col <= col;
    do @(posedge clk); while (in_stall);
    req_total++;
  endtask

  task automatic put_char(input logic [CH_W-1:0] ch);
    send_request(FUNC_PUT, ch, ROW_W'($urandom), COL_W'($urandom));
  endtask

  task automatic read_cell(input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    send_request(FUNC_READ, CH_W'($urandom), row, col);
  endtask

  // Drop valid and hold until every expected response has come back. The extra
  // edge lets the checker's count catch up with a request taken at the last edge.
  task automatic drain_responses();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Change the screen geometry only once the engine is quiet: nothing pending
  // and no scroll or clear sweep still holding the request side off.
  task automatic set_geometry(input logic [CFG_DATA_W-1:0] rows_val,
                              input logic [CFG_DATA_W-1:0] cols_val);
    drain_responses();
    while (in_stall) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ACTIVE_ROWS;
    cfg_data  <= rows_val;
    @(posedge clk);
    cfg_index <= REG_ACTIVE_COLS;
    cfg_data  <= cols_val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random traffic: a quarter reads, the rest bytes with the control codes
  // weighted up. Half the reads aim at the top-left corner where small screens
  // keep their text; the rest range over the whole address space.
  task automatic send_random(input int count);
    logic             func;
    logic [CH_W-1:0]  ch;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    int               pick;
    repeat (count) begin
      // now and then hold off until the engine has answered everything
      if ($urandom_range(0, 99) == 0) drain_responses();
      pick = $urandom_range(0, 99);
      func = FUNC_PUT;
      ch   = CH_W'($urandom_range(0, 255));
      if ($urandom_range(0, 1) == 1) begin
        row = ROW_W'($urandom_range(0, 7));
        col = COL_W'($urandom_range(0, 23));
      end else begin
        row = ROW_W'($urandom_range(0, 31));
        col = COL_W'($urandom_range(0, 127));
      end
      if (pick < 25) func = FUNC_READ;
      else if (pick < 31) ch = CH_BS;
      else if (pick < 36) ch = CH_CR;
      else if (pick < 44) ch = CH_LF;
      else if (pick == 44) ch = CH_FF;
      send_request(func, ch, row, col);
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests at the reset geometry of 25 rows by 80 columns.
    put_char(8'h00);          // zero byte is stored like any other
    put_char(8'hFF);
    put_char("A");
    read_cell(5'd0, 7'd0);
    read_cell(5'd0, 7'd1);
    read_cell(5'd24, 7'd79);  // last active cell
    read_cell(5'd25, 7'd0);   // just below the active area
    read_cell(5'd0, 7'd80);   // just right of the active area
    read_cell(5'd31, 7'd127); // far corner of the store
    put_char(CH_BS);
    put_char(CH_CR);
    put_char(CH_BS);          // backspace at home stays put
    put_char(CH_LF);
    put_char(CH_BS);          // wrap back to the end of the row above
    put_char("z");            // last column, cursor wraps to the next row
    read_cell(5'd0, 7'd79);
    put_char(8'h09);          // neighbours of the control codes are plain bytes
    put_char(8'h0B);
    put_char(8'h0E);
    put_char(8'h7F);
    put_char(8'h80);
    put_char(CH_FF);          // clear and home
    read_cell(5'd0, 7'd0);
    read_cell(5'd1, 7'd0);

    // Random phases: sender idles lightly while the receiver stalls hard, then
    // the reverse, then both run flat out.
    for (int p = 0; p < PHASES; p++) begin
      if (p == 3) begin
        send_idle_pct  = 81;
        recv_stall_pct = 8;
      end
      if (p == 6) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      set_geometry(rows_tab[p], cols_tab[p]);
      send_random(items_tab[p]);
    end

    drain_responses();
    repeat (64) @(posedge clk);

    $display("Covered %0d requests over %0d screen geometries besides the reset one;",
             req_total, PHASES);
    $display("%0d of them scrolled the screen.", scrolls_predicted);
    if (fail_count == 0 && outstanding == 0) begin
      $display("text_console_char_engine: match");
    end else begin
      $display("text_console_char_engine: mismatch");
    end
    $finish;
  end

endmodule
